// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check that cond never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- hw/rtl/abpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Block pool allocator package
// Widths, register indexes, reset values and status codes of the allocator.
// ----------------------------------------------------------------------------
package abpa_pkg;

  // Field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned BB_W      = 16;
  localparam int unsigned AL_W      = 13;
  localparam int unsigned STRIDE_W  = 17;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd3;

  // Configuration reset values
  localparam logic [ADDR_W-1:0] RST_BASE  = 32'd0;
  localparam logic [BB_W-1:0]   RST_BLOCK = 16'd64;
  localparam logic [AL_W-1:0]   RST_ALIGN = 13'd8;
  localparam logic [CNT_W-1:0]  RST_COUNT = 9'd256;

  // Request action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NONE_HELD = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

// ----- hw/rtl/abpa_if.sv -----
// ----------------------------------------------------------------------------
// Block pool allocator channels
// Request and response valid/ready channels of the allocator.
// ----------------------------------------------------------------------------
interface abpa_req_if;
  import abpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, action, free_address, input ready);
  modport sink   (input valid, action, free_address, output ready);
endinterface

interface abpa_rsp_if;
  import abpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;
  status_e           status;
  logic [CNT_W-1:0]  available;

  modport source (output valid, block_address, status, available, input ready);
  modport sink   (input valid, block_address, status, available, output ready);
endinterface

// ----- hw/rtl/aligned_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// Aligned block pool allocator
// LIFO allocator of equal-size aligned blocks with an iterative divider.
// ----------------------------------------------------------------------------
// The allocator takes one transaction at a time: req_i.ready is high only while
// the sequencer idles. An allocate that finds a free block passes through a
// free-order read, a multiply, an add and a load of the output register before
// the block can take the next transaction; an allocate on an empty pool and a
// free with nothing allocated go straight to the output register load. For a
// free, the offset from the first block is divided by the stride in a shared
// restoring divider that settles one quotient bit per cycle, followed by a
// range check and, if it passes, the allocated-flag read and the push. A free
// whose offset is not an exact multiple of the stride inside the pool is
// turned away after the range check. A finished result waits for as long as
// the output register still waits for rsp_o.ready.
// After reset and after every configuration write the pool is rebuilt: two
// passes of the same divider round the base and the block size up to the
// alignment, then a clearing pass writes one free-order entry and one allocated
// flag per cycle for each of the effective blocks. No transaction is accepted
// during the rebuild. Results sit in an output register, so the next
// transaction can be accepted while a response still waits for rsp_o.ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aligned_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [abpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [abpa_pkg::CFG_W-1:0]     cfg_wdata_i,
  abpa_req_if.sink                       req_i,
  abpa_rsp_if.source                     rsp_o
);
  import abpa_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned PROD_W  = IDX_W + STRIDE_W;
  localparam int unsigned NLIM    = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;
  localparam logic [CNT_W-1:0] NSAT = CNT_W'(NLIM);
  localparam int unsigned DCNT_W  = $clog2(ADDR_W);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(ADDR_W - 1);

  // Sequencer states
  localparam logic [3:0] S_RB_START = 4'd0;
  localparam logic [3:0] S_RB_A_DIV = 4'd1;
  localparam logic [3:0] S_RB_A_FIN = 4'd2;
  localparam logic [3:0] S_RB_B_DIV = 4'd3;
  localparam logic [3:0] S_RB_B_FIN = 4'd4;
  localparam logic [3:0] S_CLEAR    = 4'd5;
  localparam logic [3:0] S_IDLE     = 4'd6;
  localparam logic [3:0] S_ALLOC_RD = 4'd7;
  localparam logic [3:0] S_ALLOC_AD = 4'd8;
  localparam logic [3:0] S_FREE_DIV = 4'd9;
  localparam logic [3:0] S_FREE_CHK = 4'd10;
  localparam logic [3:0] S_FREE_UPD = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  // Configuration registers
  logic [ADDR_W-1:0] cfg_base_q, cfg_base_d;
  logic [BB_W-1:0]   cfg_block_q, cfg_block_d;
  logic [AL_W-1:0]   cfg_align_q, cfg_align_d;
  logic [CNT_W-1:0]  cfg_count_q, cfg_count_d;
  logic              cfg_hit;

  // Sequencer and pool state
  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    top_q, top_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    clr_q, clr_d;
  logic [ADDR_W-1:0]   first_q, first_d;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic [IDX_W-1:0]    k_q, k_d;
  logic [PROD_W-1:0]   prod_q, prod_d;

  // Pending result
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_status_q, res_status_d;
  logic [CNT_W-1:0]  res_avail_q, res_avail_d;

  // Shared restoring divider: quotient bits shift into the dividend register
  logic [ADDR_W-1:0]   div_dvd_q, div_dvd_d;
  logic [STRIDE_W-1:0] div_rem_q, div_rem_d;
  logic [STRIDE_W-1:0] div_dsr_q, div_dsr_d;
  logic [DCNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [STRIDE_W:0]   div_trial;
  logic                div_ge;
  logic [STRIDE_W-1:0] div_rem_step;

  // Output register
  logic              out_vld_q, out_vld_d;
  logic [ADDR_W-1:0] out_addr_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_avail_q;
  logic              out_load;

  // Memories
  logic [IDX_W-1:0] fo_mem [MAX_BLOCKS];
  logic             iu_mem [MAX_BLOCKS];
  logic             fo_we, iu_we, iu_wdata;
  logic [IDX_W-1:0] fo_waddr, fo_wdata, fo_raddr, fo_rd_q;
  logic [IDX_W-1:0] iu_waddr, iu_raddr;
  logic             iu_rd_q;

  // Derived configuration
  logic [AL_W-1:0]  align_eff;
  logic [BB_W-1:0]  block_eff;
  logic [CNT_W-1:0] count_eff;
  logic [AL_W-1:0]  pad;
  logic             req_acc;

  assign align_eff = (cfg_align_q == '0) ? AL_W'(1) : cfg_align_q;
  assign block_eff = (cfg_block_q == '0) ? BB_W'(1) : cfg_block_q;
  assign count_eff = (32'(cfg_count_q) > NLIM) ? NSAT : cfg_count_q;

  // Round-up padding from the remainder that the divider leaves
  assign pad = (div_rem_q == '0) ? '0 : AL_W'(align_eff - div_rem_q[AL_W-1:0]);

  assign div_trial    = {div_rem_q, div_dvd_q[ADDR_W-1]};
  assign div_ge       = div_trial >= {1'b0, div_dsr_q};
  assign div_rem_step = div_ge ? STRIDE_W'(div_trial - {1'b0, div_dsr_q})
                               : STRIDE_W'(div_trial);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  assign fo_raddr = IDX_W'(top_q - CNT_W'(1));
  assign iu_raddr = IDX_W'(div_dvd_q);

  // Configuration writes; any write restarts the rebuild
  always_comb begin
    cfg_base_d  = cfg_base_q;
    cfg_block_d = cfg_block_q;
    cfg_align_d = cfg_align_q;
    cfg_count_d = cfg_count_q;
    cfg_hit     = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE: begin
          cfg_base_d = cfg_wdata_i[ADDR_W-1:0];
          cfg_hit    = 1'b1;
        end
        CFG_BLOCK: begin
          cfg_block_d = cfg_wdata_i[BB_W-1:0];
          cfg_hit     = 1'b1;
        end
        CFG_ALIGN: begin
          cfg_align_d = cfg_wdata_i[AL_W-1:0];
          cfg_hit     = 1'b1;
        end
        CFG_COUNT: begin
          cfg_count_d = cfg_wdata_i[CNT_W-1:0];
          cfg_hit     = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    n_d          = n_q;
    clr_d        = clr_q;
    first_d      = first_q;
    stride_d     = stride_q;
    k_d          = k_q;
    prod_d       = prod_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    res_avail_d  = res_avail_q;
    div_dvd_d    = div_dvd_q;
    div_rem_d    = div_rem_q;
    div_dsr_d    = div_dsr_q;
    div_cnt_d    = div_cnt_q;
    fo_we        = 1'b0;
    fo_waddr     = '0;
    fo_wdata     = '0;
    iu_we        = 1'b0;
    iu_waddr     = '0;
    iu_wdata     = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      S_RB_START: begin
        // base mod align
        div_dvd_d = cfg_base_q;
        div_dsr_d = STRIDE_W'(align_eff);
        div_rem_d = '0;
        div_cnt_d = '0;
        state_d   = S_RB_A_DIV;
      end
      S_RB_A_DIV, S_RB_B_DIV, S_FREE_DIV: begin
        div_dvd_d = {div_dvd_q[ADDR_W-2:0], div_ge};
        div_rem_d = div_rem_step;
        div_cnt_d = div_cnt_q + DCNT_W'(1);
        if (div_cnt_q == DIV_LAST) begin
          case (state_q)
            S_RB_A_DIV: state_d = S_RB_A_FIN;
            S_RB_B_DIV: state_d = S_RB_B_FIN;
            default:    state_d = S_FREE_CHK;
          endcase
        end
      end
      S_RB_A_FIN: begin
        first_d   = cfg_base_q + ADDR_W'(pad);
        // block size mod align
        div_dvd_d = ADDR_W'(block_eff);
        div_dsr_d = STRIDE_W'(align_eff);
        div_rem_d = '0;
        div_cnt_d = '0;
        state_d   = S_RB_B_DIV;
      end
      S_RB_B_FIN: begin
        stride_d = STRIDE_W'(block_eff) + STRIDE_W'(pad);
        n_d      = count_eff;
        top_d    = '0;
        clr_d    = '0;
        state_d  = S_CLEAR;
      end
      S_CLEAR: begin
        // Lay out the free order with block 0 on top, one entry per cycle
        if (clr_q == n_q) begin
          top_d   = n_q;
          state_d = S_IDLE;
        end else begin
          fo_we    = 1'b1;
          fo_waddr = IDX_W'(clr_q);
          fo_wdata = IDX_W'(n_q - CNT_W'(1) - clr_q);
          iu_we    = 1'b1;
          iu_waddr = IDX_W'(clr_q);
          iu_wdata = 1'b0;
          clr_d    = clr_q + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          res_addr_d = '0;
          if (req_i.action == ACT_ALLOC) begin
            if (top_q == '0) begin
              res_status_d = ST_EXHAUSTED;
              res_avail_d  = '0;
              state_d      = S_EMIT;
            end else begin
              // Pop: the head entry is being read this cycle
              top_d   = top_q - CNT_W'(1);
              state_d = S_ALLOC_RD;
            end
          end else begin
            if (top_q >= n_q) begin
              res_status_d = ST_NONE_HELD;
              res_avail_d  = top_q;
              state_d      = S_EMIT;
            end else begin
              // Block index = offset / stride
              div_dvd_d = req_i.free_address - first_q;
              div_dsr_d = stride_q;
              div_rem_d = '0;
              div_cnt_d = '0;
              state_d   = S_FREE_DIV;
            end
          end
        end
      end
      S_ALLOC_RD: begin
        iu_we    = 1'b1;
        iu_waddr = fo_rd_q;
        iu_wdata = 1'b1;
        prod_d   = PROD_W'(fo_rd_q) * PROD_W'(stride_q);
        state_d  = S_ALLOC_AD;
      end
      S_ALLOC_AD: begin
        res_addr_d   = first_q + ADDR_W'(prod_q);
        res_status_d = ST_OK;
        res_avail_d  = top_q;
        state_d      = S_EMIT;
      end
      S_FREE_CHK: begin
        // Offset must be an exact multiple of the stride inside the pool
        k_d = IDX_W'(div_dvd_q);
        if ((div_rem_q != '0) || (div_dvd_q >= ADDR_W'(n_q))) begin
          res_status_d = ST_NOT_FOUND;
          res_avail_d  = top_q;
          state_d      = S_EMIT;
        end else begin
          state_d = S_FREE_UPD;
        end
      end
      S_FREE_UPD: begin
        if (!iu_rd_q) begin
          res_status_d = ST_NOT_FOUND;
          res_avail_d  = top_q;
        end else begin
          // Push the block back on top of the free order
          iu_we        = 1'b1;
          iu_waddr     = k_q;
          iu_wdata     = 1'b0;
          fo_we        = 1'b1;
          fo_waddr     = IDX_W'(top_q);
          fo_wdata     = k_q;
          top_d        = top_q + CNT_W'(1);
          res_status_d = ST_OK;
          res_avail_d  = top_q + CNT_W'(1);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_RB_START;
      end
    endcase

    if (cfg_hit) begin
      state_d = S_RB_START;
    end
  end

  assign out_vld_d = out_load || (out_vld_q && !rsp_o.ready);

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.available     = out_avail_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RB_START;
      top_q       <= '0;
      n_q         <= '0;
      clr_q       <= '0;
      div_cnt_q   <= '0;
      out_vld_q   <= 1'b0;
      cfg_base_q  <= RST_BASE;
      cfg_block_q <= RST_BLOCK;
      cfg_align_q <= RST_ALIGN;
      cfg_count_q <= RST_COUNT;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      n_q         <= n_d;
      clr_q       <= clr_d;
      div_cnt_q   <= div_cnt_d;
      out_vld_q   <= out_vld_d;
      cfg_base_q  <= cfg_base_d;
      cfg_block_q <= cfg_block_d;
      cfg_align_q <= cfg_align_d;
      cfg_count_q <= cfg_count_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    first_q      <= first_d;
    stride_q     <= stride_d;
    k_q          <= k_d;
    prod_q       <= prod_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    res_avail_q  <= res_avail_d;
    div_dvd_q    <= div_dvd_d;
    div_rem_q    <= div_rem_d;
    div_dsr_q    <= div_dsr_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
      out_avail_q  <= res_avail_q;
    end
  end

  // Free-order stack
  always_ff @(posedge clk_i) begin
    if (fo_we) begin
      fo_mem[fo_waddr] <= fo_wdata;
    end
    fo_rd_q <= fo_mem[fo_raddr];
  end

  // Allocated flags
  always_ff @(posedge clk_i) begin
    if (iu_we) begin
      iu_mem[iu_waddr] <= iu_wdata;
    end
    iu_rd_q <= iu_mem[iu_raddr];
  end

  // Free count never exceeds the pool size
  `ASSERT_NEVER(a_top_bound, clk_i, rst_ni, top_q > n_q)

  // A granted allocate pops exactly one block
  `ASSERT_PROP(a_alloc_pop, clk_i, rst_ni, (req_acc && req_i.action == ACT_ALLOC && top_q != '0 && !cfg_we_i) |=> (top_q == $past(top_q) - CNT_W'(1)))

  // An exhausted pool reports no free blocks
  `ASSERT_PROP(a_exh_empty, clk_i, rst_ni, (out_load && res_status_q == ST_EXHAUSTED) |-> (res_avail_q == '0))

endmodule

// ----- dv/abpa_pool_checker.sv -----
// ----------------------------------------------------------------------------
// Block pool allocator checker
// Watches the configuration port and both channels and predicts every
// response from its own copy of the pool. Compares responses field by field.
// ----------------------------------------------------------------------------
module abpa_pool_checker
  import abpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  abpa_req_if                  req_i,
  abpa_rsp_if                  rsp_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  localparam int unsigned POOL_DEPTH = 256;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_e           status;
    logic [CNT_W-1:0]  available;
  } pool_result_t;

  // Register copies
  logic [ADDR_W-1:0]   base_q;
  logic [BB_W-1:0]     block_bytes_q;
  logic [AL_W-1:0]     align_q;
  logic [CNT_W-1:0]    count_q;

  // Pool copy
  logic [7:0]          free_order [POOL_DEPTH];
  logic                in_use     [POOL_DEPTH];
  logic [CNT_W-1:0]    free_top;
  logic [CNT_W-1:0]    active_blocks;
  logic [ADDR_W-1:0]   first_addr;
  logic [STRIDE_W-1:0] stride;

  pool_result_t        results_due [$];

  function automatic longint unsigned ceil_multiple(longint unsigned v, longint unsigned a);
    return (v % a == 0) ? v : v + a - (v % a);
  endfunction

  function automatic void rebuild_pool();
    longint unsigned a;
    longint unsigned b;
    a = (align_q == '0) ? 1 : align_q;
    b = (block_bytes_q == '0) ? 1 : block_bytes_q;
    first_addr    = ADDR_W'(ceil_multiple(base_q, a));
    stride        = STRIDE_W'(ceil_multiple(b, a));
    active_blocks = (count_q > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : count_q;
    free_top      = active_blocks;
    for (int j = 0; j < POOL_DEPTH; j++) begin
      in_use[j]     = 1'b0;
      free_order[j] = '0;
    end
    // block 0 lands on the head of the stack
    for (int j = 0; j < active_blocks; j++) begin
      free_order[j] = 8'(active_blocks - 1 - j);
    end
  endfunction

  function automatic logic [ADDR_W-1:0] block_start(int unsigned k);
    return ADDR_W'(64'(first_addr) + 64'(k) * 64'(stride));
  endfunction

  function automatic pool_result_t pool_step(logic act, logic [ADDR_W-1:0] addr);
    pool_result_t r;
    logic [7:0]   k;
    int           hit;
    r.block_address = '0;
    r.status        = ST_OK;
    hit             = -1;
    if (act == ACT_ALLOC) begin
      if (free_top == '0) begin
        r.status = ST_EXHAUSTED;
      end else begin
        free_top        = free_top - CNT_W'(1);
        k               = free_order[free_top[7:0]];
        in_use[k]       = 1'b1;
        r.block_address = block_start(32'(k));
      end
    end else if (free_top >= active_blocks) begin
      r.status = ST_NONE_HELD;
    end else begin
      // lowest matching index wins
      for (int j = 0; j < active_blocks; j++) begin
        if (hit < 0 && in_use[j] && block_start(j) == addr) begin
          hit = j;
        end
      end
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        in_use[hit]                = 1'b0;
        free_order[free_top[7:0]]  = 8'(hit);
        free_top                   = free_top + CNT_W'(1);
      end
    end
    r.available = free_top;
    return r;
  endfunction

  function automatic void report_mismatch(bit orphan, pool_result_t due, pool_result_t seen);
    if (errors_o < 10) begin
      if (orphan) begin
        $display("%0t: response with none outstanding: addr %h status %0d avail %0d",
                 $time, seen.block_address, seen.status, seen.available);
      end else begin
        $display("%0t: mismatch: expected addr %h status %0d avail %0d, got addr %h status %0d avail %0d",
                 $time, due.block_address, due.status, due.available,
                 seen.block_address, seen.status, seen.available);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t due;
    pool_result_t seen;
    if (!rst_ni) begin
      base_q        = RST_BASE;
      block_bytes_q = RST_BLOCK;
      align_q       = RST_ALIGN;
      count_q       = RST_COUNT;
      rebuild_pool();
      results_due.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE:  base_q        = cfg_wdata_i[ADDR_W-1:0];
          CFG_BLOCK: block_bytes_q = cfg_wdata_i[BB_W-1:0];
          CFG_ALIGN: align_q       = cfg_wdata_i[AL_W-1:0];
          CFG_COUNT: count_q       = cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
        rebuild_pool();
      end
      // a response never belongs to a request taken at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        seen.block_address = rsp_i.block_address;
        seen.status        = rsp_i.status;
        seen.available     = rsp_i.available;
        if (results_due.size() == 0) begin
          report_mismatch(1'b1, seen, seen);
          errors_o <= errors_o + 1;
        end else begin
          due = results_due.pop_front();
          if (due !== seen) begin
            report_mismatch(1'b0, due, seen);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        results_due.push_back(pool_step(req_i.action, req_i.free_address));
      end
      pending_o <= results_due.size();
    end
  end

endmodule

// ----- dv/aligned_block_pool_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Aligned block pool allocator testbench
// Drives directed and random allocate/free traffic over a range of pool
// layouts, with random gaps and back-pressure; the checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module aligned_block_pool_allocator_tb;
  import abpa_pkg::*;

  localparam int unsigned NUM_SETTINGS      = 13;
  localparam int unsigned ITEMS_PER_SETTING = 90;
  // Longest quiet stretch: a rebuild of a full pool plus a free under heavy
  // stalls stays well below this.
  localparam int unsigned QUIET_LIMIT       = 4000;
  localparam int unsigned DRAIN_CYCLES      = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  abpa_req_if req ();
  abpa_rsp_if rsp ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  // Pool layout as last written; used to aim frees at real block starts.
  logic [ADDR_W-1:0] lay_first;
  longint unsigned   lay_stride;
  int unsigned       lay_blocks;

  aligned_block_pool_allocator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  abpa_pool_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req),
    .rsp_i       (rsp),
    .errors_o    (mismatches),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the response channel at the rate of the current phase.
  always @(negedge clk) begin
    rsp.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Count cycles without any transaction; give up when the block hangs.
  always @(posedge clk) begin
    if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("aligned_block_pool_allocator_tb failed");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] layout_addr(int unsigned k);
    return ADDR_W'(64'(lay_first) + 64'(k) * lay_stride);
  endfunction

  // Enter at a falling edge; return at the falling edge after the transaction.
  // Valid stays high on return so back-to-back requests never glitch it.
  task automatic send_req(input logic act, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.free_address <= addr;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Hold off until every outstanding response has been taken.
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write one register, then wait out the rebuild it starts.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] word);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= word;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic set_pool(input logic [CFG_W-1:0] base_w, input logic [CFG_W-1:0] blk_w,
                          input logic [CFG_W-1:0] aln_w, input logic [CFG_W-1:0] cnt_w);
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    write_reg(CFG_BASE, base_w);
    write_reg(CFG_BLOCK, blk_w);
    write_reg(CFG_ALIGN, aln_w);
    write_reg(CFG_COUNT, cnt_w);
    a = (aln_w[AL_W-1:0] == '0) ? 1 : aln_w[AL_W-1:0];
    b = (blk_w[BB_W-1:0] == '0) ? 1 : blk_w[BB_W-1:0];
    r = base_w[ADDR_W-1:0] % a;
    lay_first  = ADDR_W'((r != 0) ? 64'(base_w[ADDR_W-1:0]) + a - r : 64'(base_w[ADDR_W-1:0]));
    r = b % a;
    lay_stride = (r != 0) ? b + a - r : b;
    lay_blocks = (cnt_w[CNT_W-1:0] > 256) ? 256 : cnt_w[CNT_W-1:0];
  endtask

  // Mostly allocates and frees of real block starts; the rest near misses
  // and arbitrary addresses.
  task automatic send_random_item();
    int unsigned       pick;
    logic [ADDR_W-1:0] noise;
    if ($urandom_range(99) < 3) begin
      wait_drained();
    end
    pick  = $urandom_range(99);
    noise = $urandom;
    if (pick < 45) begin
      send_req(ACT_ALLOC, noise);
    end else if (lay_blocks == 0 || pick >= 92) begin
      send_req(ACT_FREE, noise);
    end else if (pick < 85) begin
      send_req(ACT_FREE, layout_addr($urandom_range(lay_blocks - 1)));
    end else begin
      send_req(ACT_FREE, layout_addr($urandom_range(lay_blocks - 1)) + $urandom_range(1, 7));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] base_w;
    logic [CFG_W-1:0] blk_w;
    logic [CFG_W-1:0] aln_w;
    logic [CFG_W-1:0] cnt_w;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_BASE;
    cfg_wdata        = '0;
    req.valid        = 1'b0;
    req.action       = ACT_ALLOC;
    req.free_address = '0;
    rsp.ready        = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    quiet_cycles     = 0;
    lay_first        = RST_BASE;
    lay_stride       = 64;
    lay_blocks       = 256;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset layout: blocks of 64 bytes from address zero.
    send_req(ACT_FREE, '0);          // nothing allocated beats the lookup
    send_req(ACT_ALLOC, '1);         // block 0 at the head
    send_req(ACT_ALLOC, '0);
    send_req(ACT_FREE, '1);          // unknown address
    send_req(ACT_FREE, 32'd65);      // inside a block, not its start
    send_req(ACT_FREE, 32'd64);
    send_req(ACT_FREE, 32'd64);      // already free
    send_req(ACT_ALLOC, '0);         // last freed comes back first
    send_req(ACT_FREE, '0);
    send_req(ACT_FREE, 32'd64);
    send_req(ACT_FREE, 32'd128);
    wait_drained();

    // Two blocks straddling the top of the address space, then run dry.
    set_pool(32'hFFFF_FFF8, 32'd8, 32'd8, 32'd2);
    send_req(ACT_ALLOC, '0);
    send_req(ACT_ALLOC, '0);
    send_req(ACT_ALLOC, '0);         // exhausted
    send_req(ACT_FREE, '0);          // wrapped block
    send_req(ACT_FREE, 32'hFFFF_FFF8);
    send_req(ACT_FREE, '0);
    send_req(ACT_ALLOC, '0);
    wait_drained();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: begin base_w = 32'h0000_1000; blk_w = 32'd64; aln_w = 32'd8; cnt_w = 32'd4; end
        1: begin base_w = '1; blk_w = 32'd1; aln_w = 32'd1; cnt_w = 32'd8; end
        2: begin base_w = 32'hFFFF_F001; blk_w = 32'hFFFF; aln_w = 32'd4096; cnt_w = 32'd3; end
        3: begin base_w = 32'h1234_5677; blk_w = '0; aln_w = '0; cnt_w = 32'd5; end
        4: begin base_w = $urandom; blk_w = 32'd100; aln_w = 32'd12; cnt_w = 32'd1; end
        5: begin base_w = '0; blk_w = 32'd48; aln_w = 32'h1FFF; cnt_w = 32'd2; end
        6: begin
          base_w = $urandom;
          blk_w  = $urandom;
          aln_w  = $urandom;
          cnt_w  = $urandom & ~32'h1FF;    // empty pool
        end
        7: begin
          base_w = $urandom;
          blk_w  = $urandom;
          aln_w  = $urandom_range(1, 64);
          cnt_w  = '1;                     // saturates to the full pool
        end
        8: begin base_w = $urandom; blk_w = 32'hFFFF; aln_w = 32'd1; cnt_w = 32'd256; end
        default: begin
          base_w = $urandom;
          blk_w  = $urandom_range(1, 300);
          case ($urandom_range(5))
            0:       aln_w = 32'd1;
            1:       aln_w = 32'd2;
            2:       aln_w = 32'd3;
            3:       aln_w = 32'd16;
            4:       aln_w = 32'd7;
            default: aln_w = 32'd4096;
          endcase
          cnt_w = $urandom_range(1, 16) | ($urandom << CNT_W);
        end
      endcase
      set_pool(base_w, blk_w, aln_w, cnt_w);

      case (s % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase

      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        send_random_item();
      end
      wait_drained();
    end

    // Let any stray response show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("aligned_block_pool_allocator_tb passed");
    end else begin
      $display("aligned_block_pool_allocator_tb failed");
    end
    $finish;
  end

endmodule
